// ===== rtl/rfb_dec_pkg.sv =====
package rfb_dec_pkg;

  // Parser phases
  typedef enum logic [4:0] {
    PhType     = 5'd0,
    PhUpdPad   = 5'd1,
    PhNRects   = 5'd2,
    PhRHdr     = 5'd3,
    PhCoding   = 5'd4,
    PhRawPix   = 5'd5,
    PhCopySrc  = 5'd6,
    PhSubEnc   = 5'd7,
    PhBg       = 5'd8,
    PhFg       = 5'd9,
    PhCount    = 5'd10,
    PhSrCol    = 5'd11,
    PhSrPos    = 5'd12,
    PhSrDim    = 5'd13,
    PhTilePix  = 5'd14,
    PhCmapHdr  = 5'd15,
    PhCutHdr   = 5'd16,
    PhSkip     = 5'd17
  } phase_e;

  // Result kinds
  localparam logic [2:0] KindPixel = 3'd0;
  localparam logic [2:0] KindFill  = 3'd1;
  localparam logic [2:0] KindMove  = 3'd2;
  localparam logic [2:0] KindDone  = 3'd3;
  localparam logic [2:0] KindError = 3'd4;

  // Error codes
  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrBounds = 2'd1;
  localparam logic [1:0] ErrCoding = 2'd2;

  // Message types
  localparam logic [7:0] MsgUpdate = 8'd0;
  localparam logic [7:0] MsgCmap   = 8'd1;
  localparam logic [7:0] MsgCut    = 8'd3;

  // Register indexes
  localparam logic [1:0] RegDepth  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // Rectangle codings
  localparam logic [31:0] CodingRaw     = 32'd0;
  localparam logic [31:0] CodingCopy    = 32'd1;
  localparam logic [31:0] CodingHextile = 32'd5;

  // Hextile sub-encoding bits
  localparam int HtRaw      = 0;
  localparam int HtBg       = 1;
  localparam int HtFg       = 2;
  localparam int HtAny      = 3;
  localparam int HtColoured = 4;

  localparam logic [16:0] TileSize = 17'd16;

  // Result queue depth
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [2:0]  kind;
    logic [16:0] dest_x;
    logic [16:0] dest_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [31:0] color;
    logic        bottom_up;
    logic        key_frame;
    logic [1:0]  error_code;
    logic        end_of_run;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [16:0] dx, logic [16:0] dy,
                                  logic [15:0] w, logic [15:0] h, logic [15:0] sx,
                                  logic [15:0] sy, logic [31:0] color, logic bu,
                                  logic key, logic [1:0] err);
    res_t r;
    r.kind       = kind;
    r.dest_x     = dx;
    r.dest_y     = dy;
    r.rect_w     = w;
    r.rect_h     = h;
    r.src_x      = sx;
    r.src_y      = sy;
    r.color      = color;
    r.bottom_up  = bu;
    r.key_frame  = key;
    r.error_code = err;
    r.end_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/remote_framebuffer_update_decoder_top.sv =====
// Decodes a server-to-client remote framebuffer byte stream, one byte per
// cycle, into drawing commands (pixel write, fill, move, frame done, error).
// Each accepted byte is parsed combinationally and its one or two commands
// go into a four-entry result queue; a byte is taken whenever the queue has
// room for two commands, so the input runs at one byte per cycle as long as
// the consumer takes one command per cycle. The user must write configuration
// through the cfg channel only while the block is idle; the block itself does
// not enforce this.
module remote_framebuffer_update_decoder_top
  import rfb_dec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // drawing commands
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [16:0] dest_x_o,
  output logic [16:0] dest_y_o,
  output logic [15:0] rect_w_o,
  output logic [15:0] rect_h_o,
  output logic [15:0] src_x_o,
  output logic [15:0] src_y_o,
  output logic [31:0] color_o,
  output logic        bottom_up_o,
  output logic        key_frame_o,
  output logic [1:0]  error_code_o,
  output logic        end_of_run_o
);

  logic [1:0]  depth_q;
  logic [15:0] fwidth_q, fheight_q;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] rects_q, rects_d;
  logic        single_q, single_d;
  logic        key_q, key_d;
  logic [15:0] rx_q, rx_d, ry_q, ry_d, rw_q, rw_d, rh_q, rh_d;
  logic [31:0] coding_q, coding_d;
  logic [15:0] msx_q, msx_d;
  logic [15:0] tx_q, tx_d, ty_q, ty_d;
  logic [4:0]  tw_q, tw_d, th_q, th_d;
  logic [4:0]  sub_q, sub_d;
  logic [7:0]  nsub_q, nsub_d;
  logic [31:0] srcol_q, srcol_d;
  logic [7:0]  srpos_q, srpos_d;
  logic [31:0] fg_q, fg_d, bg_q, bg_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] pc_q, pc_d, pr_q, pr_d;
  logic [31:0] skip_q, skip_d;

  res_t        r0, r1;
  logic [1:0]  nres;

  res_t        fifo_q [FifoDepth];
  logic [FifoAw-1:0] wp_q, rp_q;
  logic [FifoAw:0]   cnt_q;

  logic        in_acc, out_acc;
  logic [2:0]  pbytes;
  logic        tc_done;
  logic [31:0] tc_acc, tc_col;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q <= (FifoAw+1)'(FifoDepth - 2));
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o & out_ready_i;

  // Assemble a color from its bytes
  always_comb begin
    case (depth_q)
      2'd0:    pbytes = 3'd1;
      2'd1:    pbytes = 3'd2;
      default: pbytes = 3'd4;
    endcase
    tc_acc  = {acc_q[23:0], data_byte_i};
    tc_done = ({1'b0, idx_q} + 4'd1) >= {1'b0, pbytes};
    case (depth_q)
      2'd0:    tc_col = {data_byte_i, data_byte_i, data_byte_i, 8'd0};
      2'd1:    tc_col = {16'd0, tc_acc[15:0]};
      default: tc_col = tc_acc;
    endcase
  end

  // Parse one byte
  always_comb begin
    logic        tile_req, start_req, rect_req;
    logic [15:0] nr;
    logic [15:0] sy;
    logic [16:0] pc1, pr1, nx, ny, rx17, ry17;
    logic        empty;
    res_t        e;
    tile_req  = 1'b0;
    start_req = 1'b0;
    rect_req  = 1'b0;
    nr   = '0;
    sy   = '0;
    pc1  = '0;
    pr1  = '0;
    nx   = '0;
    ny   = '0;
    rx17 = '0;
    ry17 = '0;
    e    = '0;
    empty = (rw_q == '0) || (rh_q == '0);
    phase_d = phase_q; idx_d = idx_q; rects_d = rects_q; single_d = single_q;
    key_d = key_q; rx_d = rx_q; ry_d = ry_q; rw_d = rw_q; rh_d = rh_q;
    coding_d = coding_q; msx_d = msx_q; tx_d = tx_q; ty_d = ty_q;
    tw_d = tw_q; th_d = th_q; sub_d = sub_q; nsub_d = nsub_q; srcol_d = srcol_q;
    srpos_d = srpos_q; fg_d = fg_q; bg_d = bg_q; acc_d = acc_q;
    pc_d = pc_q; pr_d = pr_q; skip_d = skip_q;
    r0 = '0;
    r1 = '0;
    nres = 2'd0;

    case (phase_q)
      PhType: begin
        if (data_byte_i == MsgUpdate) begin
          phase_d = PhUpdPad; idx_d = '0;
        end else if (data_byte_i == MsgCmap) begin
          phase_d = PhCmapHdr; idx_d = '0; skip_d = '0;
        end else if (data_byte_i == MsgCut) begin
          phase_d = PhCutHdr; idx_d = '0; skip_d = '0;
        end
      end
      PhUpdPad: begin
        rects_d = '0;
        phase_d = PhNRects; idx_d = '0;
      end
      PhNRects: begin
        nr = {rects_q[7:0], data_byte_i};
        rects_d = nr;
        if (idx_q == 3'd0) begin
          idx_d = 3'd1;
        end else if (nr == '0) begin
          r0 = mk_res(KindDone, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, ErrNone);
          nres = 2'd1;
          phase_d = PhType; idx_d = '0;
        end else begin
          single_d = (nr == 16'd1);
          key_d = 1'b0;
          phase_d = PhRHdr; idx_d = '0;
        end
      end
      PhRHdr: begin
        case (idx_q[2:1])
          2'd0:    rx_d = {rx_q[7:0], data_byte_i};
          2'd1:    ry_d = {ry_q[7:0], data_byte_i};
          2'd2:    rw_d = {rw_q[7:0], data_byte_i};
          default: rh_d = {rh_q[7:0], data_byte_i};
        endcase
        if (idx_q == 3'd7) begin
          if (({1'b0, rx_d} + {1'b0, rw_d} > {1'b0, fwidth_q}) ||
              ({1'b0, ry_d} + {1'b0, rh_d} > {1'b0, fheight_q})) begin
            r0 = mk_res(KindError, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, ErrBounds);
            nres = 2'd1;
            phase_d = PhType; idx_d = '0;
          end else begin
            key_d = single_q && (rx_d == '0) && (ry_d == '0) &&
                    (rw_d == fwidth_q) && (rh_d == fheight_q);
            phase_d = PhCoding; idx_d = '0;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PhCoding: begin
        coding_d = {coding_q[23:0], data_byte_i};
        if (idx_q == 3'd3) begin
          pc_d = '0; pr_d = '0; acc_d = '0;
          if (coding_d == CodingRaw) begin
            if (empty) rect_req = 1'b1;
            else begin
              phase_d = PhRawPix; idx_d = '0;
            end
          end else if (coding_d == CodingCopy) begin
            phase_d = PhCopySrc; idx_d = '0;
          end else if (coding_d == CodingHextile) begin
            fg_d = '0; bg_d = '0; tx_d = rx_q; ty_d = ry_q;
            if (empty) rect_req = 1'b1;
            else start_req = 1'b1;
          end else if (depth_q >= 2'd2) begin
            r0 = mk_res(KindError, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, ErrCoding);
            nres = 2'd1;
            phase_d = PhType; idx_d = '0;
          end else begin
            rect_req = 1'b1;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PhRawPix, PhTilePix: begin
        acc_d = tc_done ? '0 : tc_acc;
        idx_d = tc_done ? '0 : idx_q + 3'd1;
        if (tc_done) begin
          if (phase_q == PhRawPix)
            r0 = mk_res(KindPixel, {1'b0, rx_q} + {1'b0, pc_q}, {1'b0, ry_q} + {1'b0, pr_q},
                        '0, '0, '0, '0, tc_col, 1'b0, 1'b0, ErrNone);
          else
            r0 = mk_res(KindPixel, {1'b0, tx_q} + {1'b0, pc_q}, {1'b0, ty_q} + {1'b0, pr_q},
                        '0, '0, '0, '0, tc_col, 1'b0, 1'b0, ErrNone);
          nres = 2'd1;
          pc1 = {1'b0, pc_q} + 17'd1;
          pc_d = pc1[15:0];
          if (pc1 >= ((phase_q == PhRawPix) ? {1'b0, rw_q} : {12'd0, tw_q})) begin
            pc_d = '0;
            pr1 = {1'b0, pr_q} + 17'd1;
            pr_d = pr1[15:0];
            if (pr1 >= ((phase_q == PhRawPix) ? {1'b0, rh_q} : {12'd0, th_q})) begin
              if (phase_q == PhRawPix) rect_req = 1'b1;
              else tile_req = 1'b1;
            end
          end
        end
      end
      PhCopySrc: begin
        if (idx_q < 3'd2) begin
          msx_d = {msx_q[7:0], data_byte_i};
          idx_d = idx_q + 3'd1;
        end else if (idx_q == 3'd2) begin
          acc_d = {24'd0, data_byte_i};
          idx_d = idx_q + 3'd1;
        end else begin
          sy = {acc_q[7:0], data_byte_i};
          acc_d = '0;
          r0 = mk_res(KindMove, {1'b0, rx_q}, {1'b0, ry_q}, rw_q, rh_q, msx_q, sy, '0,
                      ry_q > sy, 1'b0, ErrNone);
          nres = 2'd1;
          rect_req = 1'b1;
        end
      end
      PhSubEnc: begin
        sub_d = data_byte_i[4:0];
        acc_d = '0;
        if (sub_d[HtRaw]) begin
          pc_d = '0; pr_d = '0;
          phase_d = PhTilePix; idx_d = '0;
        end else if (sub_d[HtBg]) begin
          phase_d = PhBg; idx_d = '0;
        end else begin
          r0 = mk_res(KindFill, {1'b0, tx_q}, {1'b0, ty_q}, {11'd0, tw_q}, {11'd0, th_q},
                      '0, '0, bg_q, 1'b0, 1'b0, ErrNone);
          nres = 2'd1;
          if (sub_d[HtFg]) begin
            phase_d = PhFg; idx_d = '0;
          end else if (sub_d[HtAny]) begin
            phase_d = PhCount; idx_d = '0;
          end else tile_req = 1'b1;
        end
      end
      PhBg: begin
        acc_d = tc_done ? '0 : tc_acc;
        idx_d = tc_done ? '0 : idx_q + 3'd1;
        if (tc_done) begin
          bg_d = tc_col;
          r0 = mk_res(KindFill, {1'b0, tx_q}, {1'b0, ty_q}, {11'd0, tw_q}, {11'd0, th_q},
                      '0, '0, tc_col, 1'b0, 1'b0, ErrNone);
          nres = 2'd1;
          if (sub_q[HtFg]) begin
            phase_d = PhFg; idx_d = '0;
          end else if (sub_q[HtAny]) begin
            phase_d = PhCount; idx_d = '0;
          end else tile_req = 1'b1;
        end
      end
      PhFg: begin
        acc_d = tc_done ? '0 : tc_acc;
        idx_d = tc_done ? '0 : idx_q + 3'd1;
        if (tc_done) begin
          fg_d = tc_col;
          if (sub_q[HtAny]) begin
            phase_d = PhCount; idx_d = '0;
          end else tile_req = 1'b1;
        end
      end
      PhCount: begin
        nsub_d = data_byte_i;
        if (data_byte_i == '0) tile_req = 1'b1;
        else begin
          phase_d = sub_q[HtColoured] ? PhSrCol : PhSrPos; idx_d = '0;
        end
      end
      PhSrCol: begin
        acc_d = tc_done ? '0 : tc_acc;
        idx_d = tc_done ? '0 : idx_q + 3'd1;
        if (tc_done) begin
          srcol_d = tc_col;
          phase_d = PhSrPos;
        end
      end
      PhSrPos: begin
        srpos_d = data_byte_i;
        phase_d = PhSrDim; idx_d = '0;
      end
      PhSrDim: begin
        r0 = mk_res(KindFill, {1'b0, tx_q} + {13'd0, srpos_q[7:4]},
                    {1'b0, ty_q} + {13'd0, srpos_q[3:0]},
                    {12'd0, data_byte_i[7:4]} + 16'd1, {12'd0, data_byte_i[3:0]} + 16'd1,
                    '0, '0, sub_q[HtColoured] ? srcol_q : fg_q, 1'b0, 1'b0, ErrNone);
        nres = 2'd1;
        nsub_d = nsub_q - 8'd1;
        if (nsub_d == '0) tile_req = 1'b1;
        else begin
          phase_d = sub_q[HtColoured] ? PhSrCol : PhSrPos; idx_d = '0;
        end
      end
      PhCmapHdr: begin
        if (idx_q >= 3'd3) skip_d = {16'd0, skip_q[7:0], data_byte_i};
        if (idx_q < 3'd4) idx_d = idx_q + 3'd1;
        else begin
          skip_d = (skip_d << 2) + (skip_d << 1);
          phase_d = (skip_d == '0) ? PhType : PhSkip; idx_d = '0;
        end
      end
      PhCutHdr: begin
        if (idx_q >= 3'd3) skip_d = {skip_q[23:0], data_byte_i};
        if (idx_q < 3'd6) idx_d = idx_q + 3'd1;
        else begin
          phase_d = (skip_d == '0) ? PhType : PhSkip; idx_d = '0;
        end
      end
      PhSkip: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == '0) begin
          phase_d = PhType; idx_d = '0;
        end
      end
      default: begin
        phase_d = PhType; idx_d = '0;
      end
    endcase

    // Advance to the next tile or close the rectangle
    if (tile_req) begin
      nx = {1'b0, tx_q} + TileSize;
      ny = {1'b0, ty_q} + TileSize;
      if (nx < {1'b0, rx_q} + {1'b0, rw_q}) begin
        tx_d = nx[15:0];
        start_req = 1'b1;
      end else if (ny < {1'b0, ry_q} + {1'b0, rh_q}) begin
        tx_d = rx_q;
        ty_d = ny[15:0];
        start_req = 1'b1;
      end else begin
        rect_req = 1'b1;
      end
    end

    // Size the new tile
    if (start_req) begin
      rx17 = {1'b0, rx_q} + {1'b0, rw_q} - {1'b0, tx_d};
      ry17 = {1'b0, ry_q} + {1'b0, rh_q} - {1'b0, ty_d};
      tw_d = (rx17 < TileSize) ? rx17[4:0] : TileSize[4:0];
      th_d = (ry17 < TileSize) ? ry17[4:0] : TileSize[4:0];
      phase_d = PhSubEnc; idx_d = '0;
    end

    // Count down rectangles, report the frame at the last
    if (rect_req) begin
      rects_d = rects_q - 16'd1;
      if (rects_d == '0) begin
        e = mk_res(KindDone, '0, '0, '0, '0, '0, '0, '0, 1'b0, key_q, ErrNone);
        if (nres == 2'd0) begin
          r0 = e; nres = 2'd1;
        end else begin
          r1 = e; nres = 2'd2;
        end
        phase_d = PhType; idx_d = '0;
      end else begin
        phase_d = PhRHdr; idx_d = '0;
      end
    end

    r0.end_of_run = (nres == 2'd1);
    r1.end_of_run = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= 2'd2;
      fwidth_q  <= 16'd640;
      fheight_q <= 16'd480;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDepth:  depth_q   <= cfg_data_i[1:0];
        RegWidth:  fwidth_q  <= cfg_data_i;
        RegHeight: fheight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser state, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType; idx_q <= '0; rects_q <= '0; single_q <= 1'b0; key_q <= 1'b0;
      rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0; coding_q <= '0; msx_q <= '0;
      tx_q <= '0; ty_q <= '0; tw_q <= '0; th_q <= '0; sub_q <= '0; nsub_q <= '0;
      srcol_q <= '0; srpos_q <= '0; fg_q <= '0; bg_q <= '0; acc_q <= '0;
      pc_q <= '0; pr_q <= '0; skip_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d; idx_q <= idx_d; rects_q <= rects_d; single_q <= single_d;
      key_q <= key_d; rx_q <= rx_d; ry_q <= ry_d; rw_q <= rw_d; rh_q <= rh_d;
      coding_q <= coding_d; msx_q <= msx_d; tx_q <= tx_d; ty_q <= ty_d;
      tw_q <= tw_d; th_q <= th_d; sub_q <= sub_d; nsub_q <= nsub_d;
      srcol_q <= srcol_d; srpos_q <= srpos_d; fg_q <= fg_d; bg_q <= bg_d;
      acc_q <= acc_d; pc_q <= pc_d; pr_q <= pr_d; skip_q <= skip_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && nres != 2'd0) fifo_q[wp_q] <= r0;
    if (in_acc && nres == 2'd2) fifo_q[wp_q + FifoAw'(1)] <= r1;
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) wp_q <= wp_q + FifoAw'(nres);
      if (out_acc) rp_q <= rp_q + FifoAw'(1);
      cnt_q <= cnt_q + (in_acc ? (FifoAw+1)'(nres) : '0) - (FifoAw+1)'(out_acc);
    end
  end

  assign kind_o       = fifo_q[rp_q].kind;
  assign dest_x_o     = fifo_q[rp_q].dest_x;
  assign dest_y_o     = fifo_q[rp_q].dest_y;
  assign rect_w_o     = fifo_q[rp_q].rect_w;
  assign rect_h_o     = fifo_q[rp_q].rect_h;
  assign src_x_o      = fifo_q[rp_q].src_x;
  assign src_y_o      = fifo_q[rp_q].src_y;
  assign color_o      = fifo_q[rp_q].color;
  assign bottom_up_o  = fifo_q[rp_q].bottom_up;
  assign key_frame_o  = fifo_q[rp_q].key_frame;
  assign error_code_o = fifo_q[rp_q].error_code;
  assign end_of_run_o = fifo_q[rp_q].end_of_run;

endmodule
